// File: design/rce_pkg.sv
// ============================================================================
// rce_pkg: shared types and constants for the rational Chebyshev evaluator
// Request codes, configuration indexes, status codes and sequencer states.
// ============================================================================
package rce_pkg;

    localparam int MAX_NUM_TERMS_DEF = 16;
    localparam int MAX_DEN_TERMS_DEF = 16;

    localparam logic [1:0] REQ_NUM_WR = 2'd0;
    localparam logic [1:0] REQ_DEN_WR = 2'd1;
    localparam logic [1:0] REQ_EVAL   = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;

    localparam logic [1:0] CFG_NUM_DEG = 2'd0;
    localparam logic [1:0] CFG_DEN_DEG = 2'd1;
    localparam logic [1:0] CFG_CENTER  = 2'd2;
    localparam logic [1:0] CFG_IHW     = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DENZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

    typedef enum logic [3:0] {
        S_IDLE, S_TMUL, S_TRND, S_RD, S_MUL, S_ACC, S_DIVI, S_DIV, S_DONE
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                                 output logic s);
        s = 1'b0;
        if (v > 66'sd2147483647) begin
            s = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -66'sd2147483648) begin
            s = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // round to nearest, ties away from zero, by 2^sh
    function automatic logic signed [65:0] rshift(input logic signed [65:0] v,
                                                  input int sh);
        logic [65:0] m;
        m = v[65] ? 66'(-v) : 66'(v);
        m = (m + (66'd1 << (sh - 1))) >> sh;
        return v[65] ? -$signed(m) : $signed(m);
    endfunction

endpackage

// File: design/rce_ctab.sv
// ============================================================================
// rce_ctab: coefficient memory
// Synchronous single-port-write, one-read memory with registered read data.
// ============================================================================
module rce_ctab #(
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/rational_chebyshev_evaluator.sv
// ============================================================================
// rational_chebyshev_evaluator: rational Chebyshev series evaluator
// Stores coefficient tables and evaluates p(t)/q(t) in fixed point.
// ============================================================================
// An evaluate beat forms t in a multiply step and a rounding step; each
// series term is then one table read, one coefficient multiply (from T2 on
// also one recurrence multiply) and one accumulate through a shared
// multiplier, and the quotient comes from a radix-2 restoring divider
// producing one of 48 bits per cycle, skipped when the denominator is zero.
// The next beat is accepted once the result beat is taken.
module rational_chebyshev_evaluator
    import rce_pkg::*;
#(
    parameter int MAX_NUM_TERMS = MAX_NUM_TERMS_DEF,
    parameter int MAX_DEN_TERMS = MAX_DEN_TERMS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [3:0]         s_coeff_index,
    input  logic signed [31:0] s_coeff_value,
    input  logic signed [31:0] s_x_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_value,
    output logic [1:0]         m_status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    localparam int NAW = (MAX_NUM_TERMS > 1) ? $clog2(MAX_NUM_TERMS) : 1;
    localparam int DAW = (MAX_DEN_TERMS > 1) ? $clog2(MAX_DEN_TERMS) : 1;

    state_t state_reg, state_next;

    logic [3:0]         ndeg_reg, ddeg_reg;
    logic signed [31:0] center_reg;
    logic [30:0]        ihw_reg;

    logic signed [32:0] diff_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] t_reg, tprev_reg, tcur_reg, acc_reg, p_reg;
    logic               sat_reg, den_reg;
    logic [4:0]         i_reg, n_reg;
    logic [47:0]        num_reg;
    logic [31:0]        qm_reg;
    logic [47:0]        quo_reg;
    logic [32:0]        rem_reg;
    logic [5:0]         bit_reg;
    logic               neg_reg;

    logic [31:0] nrd, drd;
    logic        acc_s, tn_s, fin_s, t_s;
    logic signed [31:0] acc_v, tn_v, fin_v, t_v, coef;
    logic [32:0] rem_sh;
    logic signed [48:0] qs;

    assign s_ready   = (state_reg == S_IDLE) && !m_valid;
    assign cfg_ready = 1'b1;

    wire s_acc  = s_valid && s_ready;
    wire wr_num = s_acc && s_req_type == REQ_NUM_WR && 32'(s_coeff_index) < MAX_NUM_TERMS;
    wire wr_den = s_acc && s_req_type == REQ_DEN_WR && s_coeff_index != 4'd0
                  && 32'(s_coeff_index) < MAX_DEN_TERMS;

    rce_ctab #(.DEPTH(MAX_NUM_TERMS), .AW(NAW)) u_num (
        .aclk(aclk), .we(wr_num), .waddr(NAW'(s_coeff_index)),
        .wdata(s_coeff_value), .raddr(NAW'(i_reg)), .rdata(nrd)
    );
    rce_ctab #(.DEPTH(MAX_DEN_TERMS), .AW(DAW)) u_den (
        .aclk(aclk), .we(wr_den), .waddr(DAW'(s_coeff_index)),
        .wdata(s_coeff_value), .raddr(DAW'(i_reg)), .rdata(drd)
    );

    always_comb begin
        coef = den_reg ? drd : nrd;
        if (den_reg && i_reg == 5'd0) begin
            coef = ONE_Q24;
        end
        t_v   = sat32(rshift(prod_reg, 16), t_s);
        tn_v  = sat32(rshift(prod_reg, 23) - 66'(tprev_reg), tn_s);
        acc_v = sat32(66'(acc_reg) + rshift(prod_reg, 24), acc_s);
        rem_sh = {rem_reg[31:0], num_reg[47]};
        qs = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        fin_v = sat32(66'(qs), fin_s);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_acc && s_req_type == REQ_EVAL) state_next = S_TMUL;
            S_TMUL: state_next = S_TRND;
            S_TRND: state_next = S_RD;
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:  if (i_reg + 5'd1 < n_reg) state_next = S_RD;
                    else if (den_reg) state_next = S_DIVI;
                    else state_next = S_RD;
            S_DIVI: state_next = (acc_reg == 32'sd0) ? S_DONE : S_DIV;
            S_DIV:  if (bit_reg == 6'd47) state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            m_valid    <= 1'b0;
            ndeg_reg   <= 4'd5;
            ddeg_reg   <= 4'd0;
            center_reg <= 32'sd98304;
            ihw_reg    <= 31'd33554432;
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_NUM_DEG: ndeg_reg   <= cfg_data[3:0];
                    CFG_DEN_DEG: ddeg_reg   <= cfg_data[3:0];
                    CFG_CENTER:  center_reg <= cfg_data;
                    CFG_IHW:     ihw_reg    <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (state_reg == S_DONE) m_valid <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                diff_reg <= 33'(s_x_value) - 33'(center_reg);
                sat_reg  <= 1'b0;
            end
            S_TMUL: prod_reg <= 66'(diff_reg) * $signed({35'd0, ihw_reg});
            S_TRND: begin
                t_reg     <= t_v;
                sat_reg   <= t_s;
                tprev_reg <= ONE_Q24;
                tcur_reg  <= t_v;
                i_reg     <= 5'd0;
                den_reg   <= 1'b0;
                acc_reg   <= 32'sd0;
                n_reg     <= (32'(ndeg_reg) + 1 > MAX_NUM_TERMS) ?
                             5'(MAX_NUM_TERMS) : 5'(ndeg_reg) + 5'd1;
            end
            S_RD: begin
                if (i_reg >= 5'd2) begin
                    prod_reg <= 66'(t_reg) * 66'(tcur_reg);
                end
            end
            S_MUL: begin
                if (i_reg >= 5'd2) begin
                    sat_reg   <= sat_reg | tn_s;
                    prod_reg  <= 66'(coef) * 66'(tn_v);
                    tprev_reg <= tcur_reg;
                    tcur_reg  <= tn_v;
                end else if (i_reg == 5'd1) begin
                    prod_reg <= 66'(coef) * 66'(tcur_reg);
                end else begin
                    prod_reg <= 66'(coef) <<< 24;
                end
            end
            S_ACC: begin
                if (i_reg == 5'd0) acc_reg <= coef;
                else begin
                    acc_reg <= acc_v;
                    sat_reg <= sat_reg | acc_s;
                end
                i_reg <= i_reg + 5'd1;
                if (!(i_reg + 5'd1 < n_reg) && !den_reg) begin
                    p_reg     <= (i_reg == 5'd0) ? coef : acc_v;
                    den_reg   <= 1'b1;
                    i_reg     <= 5'd0;
                    acc_reg   <= 32'sd0;
                    tprev_reg <= ONE_Q24;
                    tcur_reg  <= t_reg;
                    n_reg     <= (32'(ddeg_reg) + 1 > MAX_DEN_TERMS) ?
                                 5'(MAX_DEN_TERMS) : 5'(ddeg_reg) + 5'd1;
                end
            end
            S_DIVI: begin
                prod_reg <= 66'(acc_reg);
                qm_reg   <= acc_reg[31] ? 32'(-acc_reg) : 32'(acc_reg);
                num_reg  <= {(p_reg[31] ? 32'(-p_reg) : 32'(p_reg)), 16'd0};
                neg_reg  <= p_reg[31] ^ acc_reg[31];
                den_reg  <= (acc_reg == 32'sd0);
                rem_reg  <= 33'd0;
                quo_reg  <= 48'd0;
                bit_reg  <= 6'd0;
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, qm_reg}) begin
                    rem_reg <= rem_sh - {1'b0, qm_reg};
                    quo_reg <= {quo_reg[46:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[46:0], 1'b0};
                end
                num_reg <= {num_reg[46:0], 1'b0};
                bit_reg <= bit_reg + 6'd1;
            end
            S_DONE: begin
                if (den_reg) begin
                    m_result_value <= 32'sd0;
                    m_status       <= ST_DENZ;
                end else begin
                    m_result_value <= fin_v;
                    m_status       <= (sat_reg | fin_s) ? ST_SAT : ST_OK;
                end
            end
            default: ;
        endcase
    end
endmodule

// File: tb/tb_top.sv
// ============================================================================
// tb_top: testbench for the rational Chebyshev series evaluator
// Fills both coefficient tables and sends evaluate beats under several
// interval and degree settings. A predictor in the bench works out the
// fixed-point quotient and status for each accepted evaluate, and each
// result beat is checked in order against it. Sender and receiver idle at
// random. The receiver also holds off for a long stretch so the block stalls.
// ============================================================================
module tb_top;
    import rce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int DEPTH          = 16;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
    } quotient_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_req_type;
    logic [3:0]         s_coeff_index;
    logic signed [31:0] s_coeff_value;
    logic signed [31:0] s_x_value;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_result_value;
    logic [1:0]         m_status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    rational_chebyshev_evaluator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_coeff_index(s_coeff_index), .s_coeff_value(s_coeff_value),
        .s_x_value(s_x_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_value(m_result_value),
        .m_status(m_status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    longint    num_coef [DEPTH];
    longint    den_coef [DEPTH];
    int        num_deg;
    int        den_deg;
    longint    center;
    longint    ihw;
    quotient_t pending_quotients[$];

    int  mismatches;
    int  snd_idle;
    int  rcv_idle;
    int  hold_cnt;
    bit  hold_req;
    int  quiet_cycles;

    initial begin
        aclk = 1'b0;
    end

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint round_div_pow2(longint v, int s);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : longint'(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clip32(longint v, ref bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint chebyshev_sum(longint c[DEPTH], int n, longint t, ref bit sat);
        longint acc;
        longint tprev;
        longint tcur;
        longint tnext;
        acc = c[0];
        tprev = longint'(ONE_Q24);
        tcur = t;
        if (n < 2) return acc;
        acc = clip32(acc + round_div_pow2(c[1] * tcur, 24), sat);
        for (int i = 2; i < n; i++) begin
            tnext = clip32(round_div_pow2(t * tcur, 23) - tprev, sat);
            acc = clip32(acc + round_div_pow2(c[i] * tnext, 24), sat);
            tprev = tcur;
            tcur = tnext;
        end
        return acc;
    endfunction

    function automatic quotient_t predict_quotient(logic signed [31:0] x);
        quotient_t r;
        bit        sat;
        longint    t;
        longint    p;
        longint    q;
        longint    den[DEPTH];
        longint unsigned pm;
        longint unsigned qm;
        longint    res;
        int        nn;
        int        nd;
        sat = 1'b0;
        t = clip32(round_div_pow2((longint'(x) - center) * ihw, 16), sat);
        nn = (num_deg + 1 > DEPTH) ? DEPTH : num_deg + 1;
        nd = (den_deg + 1 > DEPTH) ? DEPTH : den_deg + 1;
        den = den_coef;
        den[0] = longint'(ONE_Q24);
        p = chebyshev_sum(num_coef, nn, t, sat);
        q = chebyshev_sum(den, nd, t, sat);
        if (q == 0) begin
            r.value = '0;
            r.status = ST_DENZ;
        end else begin
            pm = (p < 0) ? longint'(-p) : longint'(p);
            qm = (q < 0) ? longint'(-q) : longint'(q);
            res = longint'((pm << 16) / qm);
            if ((p < 0) != (q < 0)) res = -res;
            res = clip32(res, sat);
            r.value = res[31:0];
            r.status = sat ? ST_SAT : ST_OK;
        end
        return r;
    endfunction

    function automatic int signed_rand(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic send_item(logic [1:0] req, logic [3:0] idx, logic [31:0] cval,
                             logic [31:0] x);
        if ($urandom_range(99) < snd_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < snd_idle);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_coeff_index <= idx;
        s_coeff_value <= cval;
        s_x_value <= x;
        do @(posedge aclk); while (!s_ready);
        case (req)
            REQ_NUM_WR: num_coef[idx] = longint'($signed(cval));
            REQ_DEN_WR: if (idx != 4'd0) den_coef[idx] = longint'($signed(cval));
            REQ_EVAL:   pending_quotients.insert(pending_quotients.size(),
                                                 predict_quotient(x));
            default: ;
        endcase
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NUM_DEG: num_deg = int'(data[3:0]);
            CFG_DEN_DEG: den_deg = int'(data[3:0]);
            CFG_CENTER:  center = longint'($signed(data));
            CFG_IHW:     ihw = longint'(data[30:0]);
            default: ;
        endcase
    endtask

    // hold the input low until every result is in and the block has settled
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_quotients.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_interval(int nd_num, int nd_den, logic [31:0] c, logic [31:0] w);
        drain();
        write_reg(CFG_NUM_DEG, nd_num);
        write_reg(CFG_DEN_DEG, nd_den);
        write_reg(CFG_CENTER, c);
        write_reg(CFG_IHW, w);
    endtask

    function automatic logic [31:0] pick_x();
        if ($urandom_range(9) == 0) return $urandom;
        return 32'(center + signed_rand(1 << 16));
    endfunction

    function automatic logic [31:0] pick_coef();
        if ($urandom_range(9) == 0) return $urandom;
        return signed_rand(1 << 23);
    endfunction

    task automatic send_random_item();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45)
            send_item(REQ_EVAL, 4'($urandom), $urandom, pick_x());
        else if (sel < 70)
            send_item(REQ_NUM_WR, 4'($urandom), pick_coef(), $urandom);
        else if (sel < 92)
            send_item(REQ_DEN_WR, 4'($urandom_range(15, 1)), pick_coef(), $urandom);
        else if (sel < 96)
            send_item(REQ_DEN_WR, 4'd0, $urandom, $urandom);
        else
            send_item(REQ_RSVD, 4'($urandom), $urandom, $urandom);
    endtask

    task automatic test_table_fill();
        for (int i = 0; i < DEPTH; i++)
            send_item(REQ_NUM_WR, 4'(i), signed_rand(1 << 23), $urandom);
        for (int i = 1; i < DEPTH; i++)
            send_item(REQ_DEN_WR, 4'(i), signed_rand(1 << 22), $urandom);
        send_item(REQ_EVAL, 4'd0, 32'd0, 32'd98304);
        send_item(REQ_EVAL, 4'd0, 32'd0, 32'd131072);
    endtask

    task automatic test_directed();
        send_item(REQ_EVAL, 4'd0, 32'd0, 32'h7fffffff);
        send_item(REQ_EVAL, 4'd0, 32'd0, 32'h80000000);
        send_item(REQ_EVAL, 4'd0, 32'd0, 32'h00000000);
        send_item(REQ_DEN_WR, 4'd0, 32'h7fffffff, 32'd0);
        send_item(REQ_RSVD, 4'hf, 32'hffffffff, 32'hffffffff);
        send_item(REQ_NUM_WR, 4'd0, 32'h7fffffff, 32'd0);
        send_item(REQ_NUM_WR, 4'd1, 32'h80000000, 32'd0);
        send_item(REQ_EVAL, 4'd0, 32'd0, 32'd131072);
        // denominator 1 - T1 vanishes at t = 1
        set_interval(3, 1, 32'd98304, 32'd33554432);
        send_item(REQ_DEN_WR, 4'd1, -32'sd16777216, 32'd0);
        send_item(REQ_EVAL, 4'd0, 32'd0, 32'd131072);
        send_item(REQ_EVAL, 4'd0, 32'd0, 32'd98304);
        set_interval(15, 15, 32'h80000000, 32'h7fffffff);
        send_item(REQ_EVAL, 4'd0, 32'd0, 32'h80000000);
        send_item(REQ_EVAL, 4'd0, 32'd0, 32'h7fffffff);
        set_interval(0, 0, 32'h7fffffff, 32'd0);
        send_item(REQ_EVAL, 4'd0, 32'd0, 32'h80000000);
        send_item(REQ_NUM_WR, 4'd0, 32'h00000000, 32'd0);
        send_item(REQ_EVAL, 4'd0, 32'd0, 32'h12345678);
        set_interval(15, 15, 32'd0, 32'd1);
        send_item(REQ_EVAL, 4'd0, 32'd0, 32'hffffffff);
    endtask

    task automatic test_random_phase(int items);
        for (int k = 0; k < 3; k++) begin
            set_interval($urandom_range(15), $urandom_range(15), signed_rand(1 << 20),
                         $urandom_range(1 << 26, 1 << 23));
            for (int i = 0; i < items / 3; i++) send_random_item();
        end
    endtask

    task automatic test_output_stall();
        drain();
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++) send_item(REQ_EVAL, 4'd0, 32'd0, pick_x());
    endtask

    task automatic test_sender_pause();
        drain();
        for (int i = 0; i < 10; i++) send_random_item();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = '0;
        s_coeff_index = '0;
        s_coeff_value = '0;
        s_x_value = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        hold_req = 1'b0;
        snd_idle = 11;
        rcv_idle = 48;
        num_deg = 5;
        den_deg = 0;
        center = 98304;
        ihw = 33554432;
        foreach (num_coef[i]) num_coef[i] = 0;
        foreach (den_coef[i]) den_coef[i] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_table_fill();
        test_directed();
        test_random_phase(222);
        test_output_stall();
        snd_idle = 48;
        rcv_idle = 11;
        test_random_phase(222);
        test_sender_pause();
        snd_idle = 0;
        rcv_idle = 0;
        test_random_phase(222);

        drain();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_quotients.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: value %h status %0d",
                             m_result_value, m_status);
            end else begin
                quotient_t e;
                e = pending_quotients.pop_front();
                if (m_result_value !== e.value || m_status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h/%0d, got %h/%0d",
                                 e.value, e.status, m_result_value, m_status);
                end
            end
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 400;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    initial begin
        m_ready = 1'b0;
        hold_cnt = 0;
        quiet_cycles = 0;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// File: files.f
design/rce_pkg.sv
design/rce_ctab.sv
design/rational_chebyshev_evaluator.sv
tb/tb_top.sv
